/* rtl/fprb_pkg.sv */
// Package with the frame phase type, codes and checksum helper for the framed packet receiver.
`timescale 1ns / 1ps

package fprb_pkg;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEN  = 3'd1,
      PH_BODY = 3'd2,
      PH_TAIL = 3'd3,
      PH_SUM  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_BAD_SUM  = 2'd1,
      STATUS_BAD_TAIL = 2'd2
   } status_type;

   localparam logic KIND_BODY    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam int unsigned CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CSR_START_BYTE = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_END_BYTE   = 8'd1;

   localparam logic [7:0] START_BYTE_RESET = 8'd204;
   localparam logic [7:0] END_BYTE_RESET   = 8'd185;

   // BSD checksum step: rotate right by one, then add the new byte mod 256.
   function automatic logic [7:0] fold_sum(input logic [7:0] sum, input logic [7:0] b);
      logic [7:0] rot;
      rot = {sum[0], sum[7:1]};
      return rot + b;
   endfunction

endpackage

/* rtl/framed_packet_receiver_bsd_checksum.sv */
// Framed packet receiver that passes body bytes on and checks an 8-bit BSD checksum.
`timescale 1ns / 1ps

// Takes one received byte per transfer and can accept a byte in every clock cycle.
// A frame is the start byte, a length byte, the body (at least one byte even when the
// length is 0), the end byte and a checksum byte. Each body byte comes out with its
// index; the checksum byte, or a wrong end byte, yields a verdict with last set. A result
// appears in the cycle after its input transfer and sits in a single output register; a
// new byte is taken whenever that register is empty or is being read in the same cycle,
// so the rate is one byte per cycle while the consumer keeps up. The user writes the start
// and end byte values via the csr port only while idle; the block does not enforce it.
module framed_packet_receiver_bsd_checksum
   import fprb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_byte_value,
   output logic [7:0]               rsp_byte_index,
   output logic [1:0]               rsp_frame_status,
   output logic                     rsp_last,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]               csr_wdata
);

   logic [7:0] start_byte_ff;
   logic [7:0] end_byte_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] body_count_ff, body_count_in;
   logic [7:0] running_sum_ff, running_sum_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_byte_value_ff, rsp_byte_value_in;
   logic [7:0] rsp_byte_index_ff, rsp_byte_index_in;
   logic [1:0] rsp_frame_status_ff, rsp_frame_status_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       accept;
   logic       emit;
   logic [7:0] count_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign count_inc = body_count_ff + 8'd1;

   // Next state of the frame parser.
   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      body_count_in   = body_count_ff;
      running_sum_in  = running_sum_ff;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_rx_byte == start_byte_ff) begin
                  phase_in       = PH_LEN;
                  body_count_in  = 8'd0;
                  running_sum_in = 8'd0;
               end
            end
            PH_LEN: begin
               frame_length_in = req_rx_byte;
               phase_in        = PH_BODY;
            end
            PH_BODY: begin
               running_sum_in = fold_sum(running_sum_ff, req_rx_byte);
               body_count_in  = count_inc;
               // A zero length still ends after one body byte, since the count is 1 then.
               if (count_inc >= frame_length_ff) begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               phase_in = (req_rx_byte == end_byte_ff) ? PH_SUM : PH_IDLE;
            end
            PH_SUM: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Result produced by the accepted byte.
   always_comb begin
      emit                = 1'b0;
      rsp_kind_in         = KIND_BODY;
      rsp_byte_value_in   = 8'd0;
      rsp_byte_index_in   = 8'd0;
      rsp_frame_status_in = STATUS_GOOD;
      rsp_last_in         = 1'b0;
      case (phase_ff)
         PH_BODY: begin
            emit              = 1'b1;
            rsp_byte_value_in = req_rx_byte;
            rsp_byte_index_in = body_count_ff;
         end
         PH_TAIL: begin
            if (req_rx_byte != end_byte_ff) begin
               emit                = 1'b1;
               rsp_kind_in         = KIND_VERDICT;
               rsp_frame_status_in = STATUS_BAD_TAIL;
               rsp_last_in         = 1'b1;
            end
         end
         PH_SUM: begin
            emit                = 1'b1;
            rsp_kind_in         = KIND_VERDICT;
            rsp_frame_status_in = (req_rx_byte == running_sum_ff) ? STATUS_GOOD
                                                                  : STATUS_BAD_SUM;
            rsp_last_in         = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= START_BYTE_RESET;
         end_byte_ff     <= END_BYTE_RESET;
         phase_ff        <= PH_IDLE;
         frame_length_ff <= 8'd0;
         body_count_ff   <= 8'd0;
         running_sum_ff  <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en && csr_index == CSR_START_BYTE) begin
            start_byte_ff <= csr_wdata;
         end
         if (csr_write_en && csr_index == CSR_END_BYTE) begin
            end_byte_ff <= csr_wdata;
         end
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         body_count_ff   <= body_count_in;
         running_sum_ff  <= running_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff         <= rsp_kind_in;
         rsp_byte_value_ff   <= rsp_byte_value_in;
         rsp_byte_index_ff   <= rsp_byte_index_in;
         rsp_frame_status_ff <= rsp_frame_status_in;
         rsp_last_ff         <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_byte_value   = rsp_byte_value_ff;
   assign rsp_byte_index   = rsp_byte_index_ff;
   assign rsp_frame_status = rsp_frame_status_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // A checksum byte always closes the frame with a verdict and returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_SUM |=>
         rsp_valid_ff && rsp_last_ff && rsp_kind_ff == KIND_VERDICT && phase_ff == PH_IDLE)
      else $error("checksum byte did not produce a closing verdict");

   // Every body byte is passed on as a body result.
   assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_BODY |=> rsp_valid_ff && rsp_kind_ff == KIND_BODY
         && !rsp_last_ff && rsp_byte_value_ff == $past(req_rx_byte))
      else $error("body byte was not passed on");

   // A byte other than the start byte keeps an idle parser idle and produces nothing.
   assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_IDLE && req_rx_byte != start_byte_ff |=>
         phase_ff == PH_IDLE && !rsp_valid_ff)
      else $error("idle parser reacted to a non-start byte");

   // The body count never runs past the frame length while in the body.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY && frame_length_ff != 8'd0 |-> body_count_ff < frame_length_ff)
      else $error("body count overran the frame length");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the framed packet receiver with its BSD checksum.
`timescale 1ns / 1ps

module testbench
   import fprb_pkg::*;
();

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam logic [CsrIndexWidth-1:0] CSR_UNMAPPED = CSR_END_BYTE + 1'b1;
   localparam logic [CsrIndexWidth-1:0] CSR_TOP      = '1;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic [7:0] index;
      status_type status;
      logic       last;
   } frame_out_type;

   typedef enum {FLAW_NONE, FLAW_CUT, FLAW_BAD_SUM, FLAW_BAD_TAIL} frame_flaw_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_rx_byte = 8'd0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_kind;
   logic [7:0]               rsp_byte_value;
   logic [7:0]               rsp_byte_index;
   logic [1:0]               rsp_frame_status;
   logic                     rsp_last;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_START_BYTE;
   logic [7:0]               csr_wdata = 8'd0;

   // Mirror of the receiver: its registers and its frame state.
   logic [7:0] sync_byte = START_BYTE_RESET;
   logic [7:0] tail_byte = END_BYTE_RESET;
   phase_type  rx_phase  = PH_IDLE;
   logic [7:0] rx_length = 8'd0;
   logic [7:0] rx_count  = 8'd0;
   logic [7:0] rx_sum    = 8'd0;

   logic [7:0]     byte_stream[$];
   frame_out_type  expected_frame_out[$];
   logic           calm = 1'b0;
   int unsigned    send_gap = 0;
   int unsigned    take_wait = 0;
   int unsigned    quiet_cycles = 0;
   int unsigned    errors = 0;
   int unsigned    bytes_taken = 0;
   int unsigned    body_seen = 0;
   int unsigned    verdicts[3] = '{0, 0, 0};

   framed_packet_receiver_bsd_checksum i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_status (rsp_frame_status),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] fold_byte(input logic [7:0] acc, input logic [7:0] b);
      return ((acc >> 1) | (acc << 7)) + b;
   endfunction

   // In calm stretches neither side idles at all.
   function automatic int unsigned draw_wait();
      if (calm)
         return 0;
      return $urandom_range(0, 4);
   endfunction

   task automatic track_frame_byte(input logic [7:0] b);
      frame_out_type res;
      logic          emit;
      res = '{kind: KIND_BODY, value: 8'd0, index: 8'd0, status: STATUS_GOOD, last: 1'b0};
      emit = 1'b0;
      case (rx_phase)
         PH_IDLE: begin
            if (b == sync_byte) begin
               rx_phase = PH_LEN;
               rx_count = 8'd0;
               rx_sum   = 8'd0;
            end
         end
         PH_LEN: begin
            rx_length = b;
            rx_phase  = PH_BODY;
         end
         PH_BODY: begin
            emit      = 1'b1;
            res.value = b;
            res.index = rx_count;
            rx_sum    = fold_byte(rx_sum, b);
            rx_count  = rx_count + 8'd1;
            // A zero length still takes one body byte, since the count is checked after it.
            if (rx_count >= rx_length)
               rx_phase = PH_TAIL;
         end
         PH_TAIL: begin
            res.kind = KIND_VERDICT;
            res.last = 1'b1;
            if (b == tail_byte) begin
               rx_phase = PH_SUM;
            end else begin
               emit       = 1'b1;
               res.status = STATUS_BAD_TAIL;
               rx_phase   = PH_IDLE;
            end
         end
         PH_SUM: begin
            emit     = 1'b1;
            res.kind = KIND_VERDICT;
            res.last = 1'b1;
            if (b != rx_sum)
               res.status = STATUS_BAD_SUM;
            rx_phase = PH_IDLE;
         end
         default: rx_phase = PH_IDLE;
      endcase
      if (emit)
         expected_frame_out.push_back(res);
   endtask

   task automatic queue_frame(input int unsigned len, input frame_flaw_type flaw);
      int unsigned n_body;
      int unsigned cut_at;
      int unsigned i;
      logic [7:0]  b;
      logic [7:0]  sum;
      n_body = (len == 0) ? 1 : len;
      cut_at = (flaw == FLAW_CUT) ? $urandom_range(0, n_body) : n_body + 1;
      sum = 8'd0;
      byte_stream.push_back(sync_byte);
      byte_stream.push_back(8'(len));
      for (i = 0; i < n_body; i++) begin
         if (i == cut_at)
            return;
         b = 8'($urandom);
         byte_stream.push_back(b);
         sum = fold_byte(sum, b);
      end
      if (flaw == FLAW_CUT)
         return;
      if (flaw == FLAW_BAD_TAIL) begin
         b = 8'($urandom);
         if (b == tail_byte)
            b = ~b;
         byte_stream.push_back(b);
         return;
      end
      byte_stream.push_back(tail_byte);
      if (flaw == FLAW_BAD_SUM)
         sum = sum ^ 8'($urandom_range(1, 255));
      byte_stream.push_back(sum);
   endtask

   task automatic queue_random_traffic(input int unsigned count);
      int unsigned    n;
      int unsigned    pick;
      int unsigned    len;
      frame_flaw_type flaw;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 3)) byte_stream.push_back(8'($urandom));
         end else begin
            if (pick < 14)
               flaw = FLAW_CUT;
            else if (pick < 26)
               flaw = FLAW_BAD_SUM;
            else if (pick < 34)
               flaw = FLAW_BAD_TAIL;
            else
               flaw = FLAW_NONE;
            pick = $urandom_range(0, 99);
            if (pick < 75)
               len = $urandom_range(0, 6);
            else if (pick < 99)
               len = $urandom_range(7, 24);
            else
               len = $urandom_range(100, 255);
            queue_frame(len, flaw);
         end
      end
   endtask

   // Waits until every byte has been taken and every result has come out.
   task automatic settle();
      @(negedge clock);
      while (byte_stream.size() != 0 || req_valid || expected_frame_out.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (byte_stream.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= byte_stream.pop_front();
            send_gap    <= draw_wait();
            if ($urandom_range(0, 39) == 0)
               calm <= !calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      int unsigned w;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_wait <= draw_wait();
      end else if (rsp_valid && rsp_ready) begin
         w = draw_wait();
         take_wait <= w;
         rsp_ready <= (w == 0);
      end else if (take_wait != 0) begin
         take_wait <= take_wait - 1;
         rsp_ready <= (take_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      frame_out_type want;
      if (!reset) begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_START_BYTE: sync_byte = csr_wdata;
               CSR_END_BYTE:   tail_byte = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            bytes_taken++;
            track_frame_byte(req_rx_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frame_out.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got kind %0d value %0d",
                        $time, rsp_kind, rsp_byte_value);
            end else begin
               want = expected_frame_out.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("byte_value", want.value, rsp_byte_value);
               check_field("byte_index", want.index, rsp_byte_index);
               check_field("frame_status", want.status, rsp_frame_status);
               check_field("last", want.last, rsp_last);
               if (want.kind == KIND_BODY)
                  body_seen++;
               else
                  verdicts[want.status]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned step;
      logic [7:0]  v;
      // Idle noise at both byte extremes, then short frames with each verdict.
      byte_stream.push_back(8'h00);
      byte_stream.push_back(8'hFF);
      queue_frame(0, FLAW_NONE);
      queue_frame(1, FLAW_BAD_TAIL);
      queue_frame(2, FLAW_BAD_SUM);
      queue_frame(3, FLAW_NONE);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (step = 0; step < 5; step++) begin
         settle();
         case (step)
            1: begin
               write_csr(CSR_START_BYTE, 8'h00);
               write_csr(CSR_END_BYTE, 8'hFF);
            end
            2: begin
               write_csr(CSR_START_BYTE, 8'hFF);
               write_csr(CSR_END_BYTE, 8'h00);
               write_csr(CSR_UNMAPPED, 8'h5A);
               write_csr(CSR_TOP, 8'hA5);
               queue_frame(255, FLAW_NONE);
            end
            3: begin
               v = 8'($urandom);
               write_csr(CSR_START_BYTE, v);
               write_csr(CSR_END_BYTE, v);
            end
            4: begin
               write_csr(CSR_START_BYTE, 8'($urandom));
               write_csr(CSR_END_BYTE, 8'($urandom));
            end
            default: ;
         endcase
         @(negedge clock);
         queue_random_traffic(11);
      end
      settle();
      $display("Run took %0d bytes and checked %0d body bytes and %0d verdicts",
               bytes_taken, body_seen, verdicts[0] + verdicts[1] + verdicts[2]);
      $display("(%0d good, %0d bad checksum, %0d bad end byte) over five marker settings.",
               verdicts[0], verdicts[1], verdicts[2]);
      if (errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

/* files.f */
rtl/fprb_pkg.sv
rtl/framed_packet_receiver_bsd_checksum.sv
tb/sv/testbench.sv
